FILE: rtl/swipe_gesture_mode_selector_core_assert.svh
// assertion macros shared by sgms_queue and sgms_back
`ifndef SWIPE_GESTURE_MODE_SELECTOR_CORE_ASSERT_SVH
`define SWIPE_GESTURE_MODE_SELECTOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SGMS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SGMS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sgms_pkg.sv
package sgms_pkg;

    localparam int PAD_W      = 4;
    localparam int LIGHT_W    = 3;
    localparam int CLASS_W    = 2;
    localparam int EFFECT_W   = 2;
    localparam int TIMEOUT_W  = 8;
    localparam int THRESH_W   = 3;
    localparam int TICKS_W    = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // pad classes
    localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_RIGHT = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_LEFT  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_TIMEOUT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = 1'd1;

    localparam logic [TIMEOUT_W-1:0] SWIPE_TIMEOUT_RST  = 8'd100;
    localparam logic [THRESH_W-1:0]  DARK_THRESHOLD_RST = 3'd2;
    localparam logic [EFFECT_W-1:0]  EFFECT_RST         = 2'd1;

    typedef struct packed {
        logic [CLASS_W-1:0] pad_class;
        logic               sleep_request;
    } sgms_item_t;

    typedef struct packed {
        logic       not_empty;
        sgms_item_t item;
    } sgms_q_out_t;

endpackage

FILE: rtl/sgms_front.sv
module sgms_front (
    input  logic [sgms_pkg::PAD_W-1:0]    pad_bits,
    input  logic [sgms_pkg::LIGHT_W-1:0]  light_level,
    input  logic [sgms_pkg::THRESH_W-1:0] dark_threshold,
    output sgms_pkg::sgms_item_t          item
);
    import sgms_pkg::*;

    logic even_pads;
    logic odd_pads;

    assign even_pads = pad_bits[0] | pad_bits[2];
    assign odd_pads  = pad_bits[1] | pad_bits[3];

    always_comb begin
        if (odd_pads && !even_pads) begin
            item.pad_class = CLASS_LEFT;
        end else if (even_pads && !odd_pads) begin
            item.pad_class = CLASS_RIGHT;
        end else begin
            item.pad_class = CLASS_OTHER;
        end
        item.sleep_request = (light_level < dark_threshold);
    end

endmodule

FILE: rtl/sgms_queue.sv
module sgms_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  sgms_pkg::sgms_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output sgms_pkg::sgms_q_out_t q_out
);
    import sgms_pkg::*;

    `include "swipe_gesture_mode_selector_core_assert.svh"

    sgms_item_t          mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        logic [QUEUE_AW-1:0] r;
        if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full            = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_out.not_empty = (count_reg != '0);
    assign q_out.item      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `SGMS_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= QUEUE_CW'(QUEUE_DEPTH), "queue count beyond depth")
    `SGMS_ASSERT_IMPL(a_no_overflow_underflow, aclk, aresetn, push || pop,
        !(push && full) && !(pop && !q_out.not_empty), "queue overflow or underflow")

endmodule

FILE: rtl/sgms_back.sv
module sgms_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [sgms_pkg::TIMEOUT_W-1:0]     swipe_timeout,
    input  sgms_pkg::sgms_q_out_t              q_out,
    output logic                               pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sgms_pkg::CLASS_W-1:0]       m_pad_class,
    output logic [sgms_pkg::EFFECT_W-1:0]      m_effect_select,
    output logic                               m_effect_changed,
    output logic                               m_sleep_request
);
    import sgms_pkg::*;

    `include "swipe_gesture_mode_selector_core_assert.svh"

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_SAW_RIGHT = 3'd1;
    localparam logic [2:0] PH_SAW_LEFT  = 3'd2;
    localparam logic [2:0] PH_DOWN      = 3'd3;
    localparam logic [2:0] PH_UP        = 3'd4;

    logic [2:0]          phase_reg, phase_next;
    logic [TICKS_W-1:0]  ticks_reg, ticks_next;
    logic [EFFECT_W-1:0] effect_reg, effect_next;
    logic                changed_next;
    logic                timed_out;
    logic                m_valid_reg;
    logic [CLASS_W-1:0]  m_pad_class_reg;
    logic [EFFECT_W-1:0] m_effect_select_reg;
    logic                m_effect_changed_reg;
    logic                m_sleep_request_reg;

    // output register empty or draining this cycle
    assign pop       = q_out.not_empty && (!m_valid_reg || m_ready);
    assign timed_out = (ticks_reg >= {1'b0, swipe_timeout});

    always_comb begin
        phase_next   = phase_reg;
        ticks_next   = ticks_reg;
        effect_next  = effect_reg;
        changed_next = 1'b0;
        case (phase_reg)
            PH_SAW_RIGHT: begin
                if (timed_out) begin
                    phase_next = PH_IDLE;
                end else if (q_out.item.pad_class == CLASS_LEFT) begin
                    phase_next = PH_DOWN;
                end
                ticks_next = ticks_reg + 1'b1;
            end
            PH_SAW_LEFT: begin
                if (timed_out) begin
                    phase_next = PH_IDLE;
                end else if (q_out.item.pad_class == CLASS_RIGHT) begin
                    phase_next = PH_UP;
                end
                ticks_next = ticks_reg + 1'b1;
            end
            PH_DOWN: begin
                effect_next  = (effect_reg < 2'd2) ? 2'd3 : effect_reg - 1'b1;
                phase_next   = PH_IDLE;
                changed_next = 1'b1;
            end
            PH_UP: begin
                effect_next  = (effect_reg > 2'd2) ? 2'd1 : effect_reg + 1'b1;
                phase_next   = PH_IDLE;
                changed_next = 1'b1;
            end
            default: begin
                if (q_out.item.pad_class == CLASS_RIGHT) begin
                    phase_next = PH_SAW_RIGHT;
                end else if (q_out.item.pad_class == CLASS_LEFT) begin
                    phase_next = PH_SAW_LEFT;
                end else begin
                    phase_next = PH_IDLE;
                end
                ticks_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            ticks_reg   <= '0;
            effect_reg  <= EFFECT_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg  <= phase_next;
                ticks_reg  <= ticks_next;
                effect_reg <= effect_next;
            end
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_pad_class_reg      <= q_out.item.pad_class;
            m_effect_select_reg  <= effect_next;
            m_effect_changed_reg <= changed_next;
            m_sleep_request_reg  <= q_out.item.sleep_request;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pad_class      = m_pad_class_reg;
    assign m_effect_select  = m_effect_select_reg;
    assign m_effect_changed = m_effect_changed_reg;
    assign m_sleep_request  = m_sleep_request_reg;

    `SGMS_ASSERT_NEXT(a_pending_swipe_steps, aclk, aresetn,
        pop && (phase_reg == PH_DOWN || phase_reg == PH_UP),
        m_valid && m_effect_changed && phase_reg == PH_IDLE,
        "pending swipe did not step the effect")
    `SGMS_ASSERT_IMPL(a_state_range, aclk, aresetn, 1'b1,
        phase_reg <= PH_UP && ticks_reg <= 9'd256 && effect_reg != 2'd0,
        "swipe state out of range")
    `SGMS_ASSERT_NEXT(a_held_while_stalled, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_effect_select) && $stable(effect_reg),
        "result or effect moved while stalled")

endmodule

FILE: rtl/swipe_gesture_mode_selector_core.sv
// channel  | beat contents                                        | handshake
// s_       | s_pad_bits, s_light_level                            | s_valid / s_ready
// m_       | m_pad_class, m_effect_select, m_effect_changed,      | m_valid / m_ready
//          | m_sleep_request                                      |
// cfg_     | cfg_index, cfg_wdata                                 | cfg_wr_en
//
// one beat per cycle unless m_ready stalls; beats pass the queue, then the output register
// front classifies pads and light level, a two-entry queue feeds the gesture machine
// the gesture machine updates once per beat, so it sets the one-cycle rate
// s_ready drops only when the queue is full because m_ready has stalled
// synchronous reset: effect 1, idle gesture, timeout 100, dark threshold 2
module swipe_gesture_mode_selector_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sgms_pkg::PAD_W-1:0]         s_pad_bits,
    input  logic [sgms_pkg::LIGHT_W-1:0]       s_light_level,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sgms_pkg::CLASS_W-1:0]       m_pad_class,
    output logic [sgms_pkg::EFFECT_W-1:0]      m_effect_select,
    output logic                               m_effect_changed,
    output logic                               m_sleep_request,
    input  logic                               cfg_wr_en,
    input  logic [sgms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sgms_pkg::*;

    logic [TIMEOUT_W-1:0] swipe_timeout_reg;
    logic [THRESH_W-1:0]  dark_threshold_reg;
    sgms_item_t           front_item;
    sgms_q_out_t          q_out;
    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swipe_timeout_reg  <= SWIPE_TIMEOUT_RST;
            dark_threshold_reg <= DARK_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SWIPE_TIMEOUT:  swipe_timeout_reg  <= cfg_wdata[TIMEOUT_W-1:0];
                CFG_DARK_THRESHOLD: dark_threshold_reg <= cfg_wdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    sgms_front u_front (
        .pad_bits       (s_pad_bits),
        .light_level    (s_light_level),
        .dark_threshold (dark_threshold_reg),
        .item           (front_item)
    );

    sgms_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_out     (q_out)
    );

    sgms_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .swipe_timeout    (swipe_timeout_reg),
        .q_out            (q_out),
        .pop              (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pad_class      (m_pad_class),
        .m_effect_select  (m_effect_select),
        .m_effect_changed (m_effect_changed),
        .m_sleep_request  (m_sleep_request)
    );

endmodule

FILE: sim/tb_swipe_gesture_mode_selector_core.sv
module tb_swipe_gesture_mode_selector_core;
    import sgms_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_SAMPLES = 65;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_SAW_RIGHT,
        GS_SAW_LEFT,
        GS_DOWN_PENDING,
        GS_UP_PENDING
    } gesture_state_t;

    typedef struct packed {
        logic [CLASS_W-1:0]  pad_class;
        logic [EFFECT_W-1:0] effect_select;
        logic                effect_changed;
        logic                sleep_request;
    } sample_result_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic [PAD_W-1:0]      s_pad_bits    = '0;
    logic [LIGHT_W-1:0]    s_light_level = '0;
    logic                  m_ready       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    logic                  s_ready;
    logic                  m_valid;
    logic [CLASS_W-1:0]    m_pad_class;
    logic [EFFECT_W-1:0]   m_effect_select;
    logic                  m_effect_changed;
    logic                  m_sleep_request;

    swipe_gesture_mode_selector_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pad_bits       (s_pad_bits),
        .s_light_level    (s_light_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pad_class      (m_pad_class),
        .m_effect_select  (m_effect_select),
        .m_effect_changed (m_effect_changed),
        .m_sleep_request  (m_sleep_request),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    // tracks the gesture machine and the effect, holds the results still owed
    class effect_tracker;
        gesture_state_t       state;
        logic [TICKS_W-1:0]   ticks;
        logic [EFFECT_W-1:0]  effect;
        logic [TIMEOUT_W-1:0] timeout;
        logic [THRESH_W-1:0]  threshold;
        sample_result_t       owed[$];
        int                   failures;

        function new();
            state     = GS_IDLE;
            ticks     = '0;
            effect    = EFFECT_RST;
            timeout   = SWIPE_TIMEOUT_RST;
            threshold = DARK_THRESHOLD_RST;
            failures  = 0;
        endfunction

        static function logic [CLASS_W-1:0] classify(input logic [PAD_W-1:0] pads);
            logic even_side;
            logic odd_side;
            even_side = pads[0] | pads[2];
            odd_side  = pads[1] | pads[3];
            if (odd_side && !even_side) return CLASS_LEFT;
            if (even_side && !odd_side) return CLASS_RIGHT;
            return CLASS_OTHER;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SWIPE_TIMEOUT) begin
                timeout = data[TIMEOUT_W-1:0];
            end else if (idx == CFG_DARK_THRESHOLD) begin
                threshold = data[THRESH_W-1:0];
            end
        endfunction

        function void note_sample(input logic [PAD_W-1:0] pads,
                                  input logic [LIGHT_W-1:0] light);
            sample_result_t r;
            r.pad_class      = classify(pads);
            r.effect_changed = 1'b0;
            case (state)
                GS_SAW_RIGHT, GS_SAW_LEFT: begin
                    if (ticks >= {1'b0, timeout}) begin
                        state = GS_IDLE;
                    end else if (state == GS_SAW_RIGHT && r.pad_class == CLASS_LEFT) begin
                        state = GS_DOWN_PENDING;
                    end else if (state == GS_SAW_LEFT && r.pad_class == CLASS_RIGHT) begin
                        state = GS_UP_PENDING;
                    end
                    ticks = ticks + 1'b1;
                end
                // pending swipes ignore the pads of this beat
                GS_DOWN_PENDING: begin
                    effect           = (effect < 2'd2) ? 2'd3 : effect - 2'd1;
                    state            = GS_IDLE;
                    r.effect_changed = 1'b1;
                end
                GS_UP_PENDING: begin
                    effect           = (effect > 2'd2) ? 2'd1 : effect + 2'd1;
                    state            = GS_IDLE;
                    r.effect_changed = 1'b1;
                end
                default: begin
                    if (r.pad_class == CLASS_RIGHT) begin
                        state = GS_SAW_RIGHT;
                    end else if (r.pad_class == CLASS_LEFT) begin
                        state = GS_SAW_LEFT;
                    end else begin
                        state = GS_IDLE;
                    end
                    ticks = '0;
                end
            endcase
            r.effect_select = effect;
            r.sleep_request = (light < threshold);
            owed.push_back(r);
        endfunction

        function void check_result(input sample_result_t got);
            sample_result_t want;
            if (owed.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("unexpected result beat: class %0d effect %0d changed %0d sleep %0d",
                             got.pad_class, got.effect_select, got.effect_changed,
                             got.sleep_request);
                end
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("result mismatch: expected class %0d effect %0d changed %0d sleep %0d",
                             want.pad_class, want.effect_select, want.effect_changed,
                             want.sleep_request);
                    $display("                 actual   class %0d effect %0d changed %0d sleep %0d",
                             got.pad_class, got.effect_select, got.effect_changed,
                             got.sleep_request);
                end
            end
        endfunction

        function int owed_count();
            return owed.size();
        endfunction

        function void close_out();
            if (owed.size() != 0) begin
                failures += owed.size();
                $display("%0d result beats never arrived", owed.size());
            end
        endfunction
    endclass

    effect_tracker tracker;
    int            samples_sent = 0;
    int            cycle_count  = 0;
    int            rx_hold      = 0;
    bit            tx_steady    = 1'b0;
    bit            rx_steady    = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    always @(posedge aclk) begin
        int g;
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            g       = gap_length(rx_steady);
            rx_hold = (g > 0) ? g - 1 : 0;
            m_ready <= (g == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_sample(s_pad_bits, s_light_level);
            end
            if (m_valid && m_ready) begin
                tracker.check_result({m_pad_class, m_effect_select, m_effect_changed,
                                      m_sleep_request});
            end
        end
    end

    function automatic logic [PAD_W-1:0] rand_pads();
        return PAD_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [LIGHT_W-1:0] rand_light();
        return LIGHT_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [PAD_W-1:0] pads_of(input logic [CLASS_W-1:0] cls);
        logic [PAD_W-1:0] p;
        do begin
            p = rand_pads();
        end while (effect_tracker::classify(p) != cls);
        return p;
    endfunction

    task automatic send_sample(input logic [PAD_W-1:0] pads, input logic [LIGHT_W-1:0] light);
        int gap;
        gap = gap_length(tx_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pad_bits    <= pads;
        s_light_level <= light;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // first pad, some waiting beats, then optionally the opposite pad and one more beat
    task automatic swipe(input bit from_left, input int fillers, input bit finish);
        logic [CLASS_W-1:0] first_side;
        logic [CLASS_W-1:0] second_side;
        first_side  = from_left ? CLASS_LEFT : CLASS_RIGHT;
        second_side = from_left ? CLASS_RIGHT : CLASS_LEFT;
        send_sample(pads_of(first_side), rand_light());
        repeat (fillers) begin
            send_sample(pads_of(($urandom_range(0, 2) == 0) ? first_side : CLASS_OTHER),
                        rand_light());
        end
        if (finish) begin
            send_sample(pads_of(second_side), rand_light());
            send_sample(rand_pads(), rand_light());
        end
    endtask

    task automatic run_gestures(input int count);
        int goal;
        int r;
        int fillers;
        goal = samples_sent + count;
        while (samples_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // aim at the timeout boundary when it is short enough to reach
                if (tracker.timeout <= 20 && $urandom_range(0, 3) == 0) begin
                    fillers = int'(tracker.timeout) + int'($urandom_range(0, 2)) - 1;
                    if (fillers < 0) fillers = 0;
                end else begin
                    fillers = $urandom_range(0, 5);
                end
                swipe(bit'($urandom_range(0, 1)), fillers, 1'b1);
            end else if (r < 85) begin
                swipe(bit'($urandom_range(0, 1)), $urandom_range(0, 3), 1'b0);
            end else begin
                send_sample(rand_pads(), rand_light());
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.owed_count() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [TIMEOUT_W-1:0] timeout,
                              input logic [THRESH_W-1:0] threshold);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SWIPE_TIMEOUT;
        cfg_wdata <= CFG_DATA_W'(timeout);
        @(posedge aclk);
        tracker.write_reg(CFG_SWIPE_TIMEOUT, CFG_DATA_W'(timeout));
        cfg_index <= CFG_DARK_THRESHOLD;
        cfg_wdata <= CFG_DATA_W'(threshold);
        @(posedge aclk);
        tracker.write_reg(CFG_DARK_THRESHOLD, CFG_DATA_W'(threshold));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [TIMEOUT_W-1:0] tmo;
        logic [THRESH_W-1:0]  thr;
        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: every pad pattern, both swipe directions, wrap both ways
        send_sample(4'h1, 3'd0);
        send_sample(4'h2, 3'd7);
        send_sample(4'hF, 3'd1);
        send_sample(4'h8, 3'd2);
        send_sample(4'h4, 3'd3);
        send_sample(4'h0, 3'd4);
        send_sample(4'h5, 3'd5);
        send_sample(4'h5, 3'd6);
        send_sample(4'hA, 3'd7);
        send_sample(4'h2, 3'd0);
        send_sample(4'h6, 3'd1);
        send_sample(4'h9, 3'd2);
        send_sample(4'hA, 3'd3);
        send_sample(4'h3, 3'd4);
        send_sample(4'hC, 3'd5);
        send_sample(4'h1, 3'd6);
        send_sample(4'h4, 3'd7);
        send_sample(4'h7, 3'd0);
        send_sample(4'hB, 3'd1);
        send_sample(4'hD, 3'd6);
        send_sample(4'hE, 3'd7);
        drain();

        // longest timeout: the wait runs out just as the second pad comes
        set_config(8'd255, 3'd7);
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        swipe(1'b0, 255, 1'b1);
        tx_steady = 1'b0;
        run_gestures(30);
        drain();

        for (int i = 0; i < 6; i++) begin
            case (i)
                0: begin tmo = 8'd0;  thr = 3'd0; end
                1: begin tmo = 8'd1;  thr = 3'd4; end
                2: begin tmo = 8'd3;  thr = 3'd1; end
                3: begin tmo = 8'd6;  thr = 3'd6; end
                4: begin
                    tmo = TIMEOUT_W'($urandom_range(0, 20));
                    thr = rand_light();
                end
                default: begin
                    tmo = TIMEOUT_W'($urandom_range(0, 255));
                    thr = rand_light();
                end
            endcase
            set_config(tmo, thr);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            run_gestures(PHASE_SAMPLES);
            drain();
        end

        tracker.close_out();
        if (tracker.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sgms_pkg.sv
rtl/sgms_front.sv
rtl/sgms_queue.sv
rtl/sgms_back.sv
rtl/swipe_gesture_mode_selector_core.sv
sim/tb_swipe_gesture_mode_selector_core.sv
